// ===== sv/svpwm_pkg.sv =====
// shared types, constants and helpers of the svpwm duty generator
package svpwm_pkg;

    localparam int QBITS   = 15;   // quotient bits of the duty offset
    localparam int REMW    = 51;   // width of |numerator| * period
    localparam int DENW    = 36;   // width of twice the denominator
    localparam int PHW     = 34;   // phase voltage width in q16 scaling
    localparam int DIV_STG = QBITS;
    localparam int FRONT_STG = 5;
    localparam int NSTG    = FRONT_STG + DIV_STG + 1;

    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
    localparam logic signed [18:0] SQRT3_Q16      = 19'sd113512;

    localparam logic [14:0] BUS_RESET     = 15'd6144;
    localparam logic [15:0] PERIOD_RESET  = 16'd4250;
    localparam logic [15:0] NEUTRAL_RESET = 16'd2125;

    typedef enum logic [1:0] {
        REG_BUS     = 2'd0,
        REG_PERIOD  = 2'd1,
        REG_NEUTRAL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0][REMW-1:0]  rem;
        logic [2:0][QBITS-1:0] quo;
        logic [2:0]            neg;
        logic [DENW-1:0]       den2;
        logic                  zero;
        logic                  over;
        logic [2:0]            sector;
    } div_t;

    // sign pattern of u1, u2, u3 to sector number
    function automatic logic [2:0] sector_of(input logic [2:0] w);
        logic [2:0] s;
        case (w)
            3'd3:    s = 3'd1;
            3'd1:    s = 3'd2;
            3'd5:    s = 3'd3;
            3'd4:    s = 3'd4;
            3'd6:    s = 3'd5;
            3'd2:    s = 3'd6;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/svpwm_front.sv =====
// inverse clarke, min/max, span scaling and numerator product stages
module svpwm_front (
    input  logic                        aclk,
    input  logic [svpwm_pkg::FRONT_STG-1:0] adv,
    input  logic signed [15:0]          alpha_volts,
    input  logic signed [15:0]          beta_volts,
    input  logic [14:0]                 bus_voltage,
    input  logic [15:0]                 pwm_period,
    output svpwm_pkg::div_t             div_out
);

    localparam int PHW = svpwm_pkg::PHW;

    // stage 0: products
    logic signed [15:0]  alpha_reg, beta_reg;
    logic signed [33:0]  sb_reg;
    logic signed [35:0]  sa3_reg;
    logic signed [33:0]  sb_next;
    logic signed [35:0]  sa3_next;

    assign sb_next  = beta_volts * svpwm_pkg::SQRT3_HALF_Q16;
    assign sa3_next = alpha_volts * svpwm_pkg::SQRT3_Q16;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            alpha_reg <= alpha_volts;
            beta_reg  <= beta_volts;
            sb_reg    <= sb_next;
            sa3_reg   <= sa3_next;
        end
    end

    // stage 1: phases and sector
    logic signed [PHW-1:0] pa_reg, pb_reg, pc_reg;
    logic [2:0]            sec1_reg;
    logic signed [PHW-1:0] pa_next, half_v, pb_next, pc_next;
    logic signed [35:0]    beta_q, u2, u3;
    logic [2:0]            w_bits;

    always_comb begin
        pa_next = PHW'(alpha_reg) <<< 16;
        half_v  = -(PHW'(alpha_reg) <<< 15);
        pb_next = half_v + PHW'(sb_reg);
        pc_next = half_v - PHW'(sb_reg);
        beta_q  = 36'(beta_reg) <<< 16;
        u2      = sa3_reg - beta_q;
        u3      = -sa3_reg - beta_q;
        w_bits  = {u3 > 36'sd0, u2 > 36'sd0, beta_reg > 16'sd0};
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            sec1_reg <= svpwm_pkg::sector_of(w_bits);
        end
    end

    // stage 2: max and min
    logic signed [PHW-1:0] p2_reg [3];
    logic signed [PHW-1:0] mx_reg, mn_reg;
    logic [2:0]            sec2_reg;
    logic signed [PHW-1:0] mx_next, mn_next;

    always_comb begin
        mx_next = pa_reg;
        mn_next = pa_reg;
        if (pb_reg > mx_next) mx_next = pb_reg;
        if (pc_reg > mx_next) mx_next = pc_reg;
        if (pb_reg < mn_next) mn_next = pb_reg;
        if (pc_reg < mn_next) mn_next = pc_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            p2_reg[0] <= pa_reg;
            p2_reg[1] <= pb_reg;
            p2_reg[2] <= pc_reg;
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;
            sec2_reg  <= sec1_reg;
        end
    end

    // stage 3: span, denominator and centered numerators
    logic [2:0][34:0] mag_reg;
    logic [2:0]       neg_reg;
    logic [34:0]      den_reg;
    logic             over_reg;
    logic [2:0]       sec3_reg;
    logic signed [34:0] span_s;
    logic [30:0]        bus_q;
    logic               over_next;
    logic [2:0][34:0]   mag_next;
    logic [2:0]         neg_next;
    logic signed [35:0] nx [3];

    always_comb begin
        span_s    = 35'(mx_reg) - 35'(mn_reg);
        bus_q     = {bus_voltage, 16'b0};
        over_next = span_s > $signed({4'b0, bus_q});
        for (int i = 0; i < 3; i++) begin
            nx[i]       = (36'(p2_reg[i]) <<< 1) - 36'(mx_reg) - 36'(mn_reg);
            neg_next[i] = nx[i] < 36'sd0;
            mag_next[i] = neg_next[i] ? 35'(-nx[i]) : 35'(nx[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            den_reg  <= over_next ? 35'(span_s) : 35'(bus_q);
            over_reg <= over_next;
            sec3_reg <= sec2_reg;
        end
    end

    // stage 4: numerator times period
    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                div_out.rem[i] <= svpwm_pkg::REMW'(mag_reg[i]) *
                                  svpwm_pkg::REMW'(pwm_period);
            end
            div_out.quo    <= '0;
            div_out.neg    <= neg_reg;
            div_out.den2   <= {den_reg, 1'b0};
            div_out.zero   <= den_reg == 35'd0;
            div_out.over   <= over_reg;
            div_out.sector <= sec3_reg;
        end
    end

endmodule

// ===== sv/svpwm_div_stage.sv =====
// one restoring division step for the three phase lanes
module svpwm_div_stage #(
    parameter int BIT = 0
) (
    input  logic            aclk,
    input  logic            adv,
    input  svpwm_pkg::div_t div_in,
    output svpwm_pkg::div_t div_out
);

    localparam int REMW = svpwm_pkg::REMW;

    logic [REMW-1:0] dsh;
    svpwm_pkg::div_t div_next;

    always_comb begin
        dsh      = REMW'(div_in.den2) << BIT;
        div_next = div_in;
        for (int i = 0; i < 3; i++) begin
            if (div_in.rem[i] >= dsh) begin
                div_next.rem[i] = div_in.rem[i] - dsh;
                div_next.quo[i] = div_in.quo[i] |
                                  (svpwm_pkg::QBITS'(1) << BIT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_out <= div_next;
        end
    end

endmodule

// ===== sv/svpwm_back.sv =====
// floor correction, neutral offset and clamp to the period
module svpwm_back (
    input  logic            aclk,
    input  logic            adv,
    input  svpwm_pkg::div_t div_in,
    input  logic [15:0]     pwm_period,
    input  logic [15:0]     neutral_count,
    output logic [15:0]     duty_a,
    output logic [15:0]     duty_b,
    output logic [15:0]     duty_c,
    output logic [2:0]      sector,
    output logic            overmodulated
);

    logic [2:0][15:0]   duty_next;
    logic signed [16:0] q17 [3];
    logic signed [16:0] off [3];
    logic signed [17:0] total [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // negative quotients round toward minus infinity
            q17[i] = $signed({2'b0, div_in.quo[i]}) +
                     $signed({16'b0, div_in.rem[i] != '0 && div_in.neg[i]});
            off[i] = div_in.neg[i] ? -q17[i] : q17[i];
            if (div_in.zero) off[i] = 17'sd0;
            total[i] = $signed({2'b0, neutral_count}) + 18'(off[i]);
            if (total[i] < 18'sd0) begin
                duty_next[i] = 16'd0;
            end else if (total[i] > $signed({2'b0, pwm_period})) begin
                duty_next[i] = pwm_period;
            end else begin
                duty_next[i] = total[i][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            duty_a        <= duty_next[0];
            duty_b        <= duty_next[1];
            duty_c        <= duty_next[2];
            sector        <= div_in.sector;
            overmodulated <= div_in.over;
        end
    end

endmodule

// ===== sv/svpwm_duty_generator.sv =====
// top level of the space vector pwm duty generator
//
// Usage: an alpha/beta voltage command enters on the s_ channel (valid/ready)
// and one result with three compare counts, the sector and the
// overmodulation flag leaves on the m_ channel (valid/ready).
// The pipeline has 21 register stages: five arithmetic stages (products,
// phases, min/max, span, numerator times period), fifteen restoring
// division steps (one quotient bit per stage, three phase lanes) and the
// output register. It takes one request per cycle unless every stage is
// full and m_ready is low.
// Each stage only holds when its successor is full and stalled, so bubbles
// are squeezed out while m_ready is low and s_ready drops only when every
// stage holds a request.
// Configuration writes (bus voltage, period, neutral count) take effect at
// the next edge; write them only while the pipeline is empty.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// default register values; no request is lost or repeated during a stall.
module svpwm_duty_generator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_alpha_volts,
    input  logic signed [15:0] s_beta_volts,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_duty_a,
    output logic [15:0]        m_duty_b,
    output logic [15:0]        m_duty_c,
    output logic [2:0]         m_sector,
    output logic               m_overmodulated
);

    localparam int NSTG = svpwm_pkg::NSTG;
    localparam int FST  = svpwm_pkg::FRONT_STG;
    localparam int DST  = svpwm_pkg::DIV_STG;

    logic [14:0] bus_reg;
    logic [15:0] period_reg, neutral_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg     <= svpwm_pkg::BUS_RESET;
            period_reg  <= svpwm_pkg::PERIOD_RESET;
            neutral_reg <= svpwm_pkg::NEUTRAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                svpwm_pkg::REG_BUS:     bus_reg     <= cfg_data[14:0];
                svpwm_pkg::REG_PERIOD:  period_reg  <= cfg_data;
                svpwm_pkg::REG_NEUTRAL: neutral_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits per stage and the hold chain
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;

    always_comb begin
        rdy[NSTG] = m_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= s_valid;
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NSTG-1];

    svpwm_pkg::div_t dchain [DST+1];

    svpwm_front u_front (
        .aclk        (aclk),
        .adv         (rdy[FST-1:0]),
        .alpha_volts (s_alpha_volts),
        .beta_volts  (s_beta_volts),
        .bus_voltage (bus_reg),
        .pwm_period  (period_reg),
        .div_out     (dchain[0])
    );

    for (genvar k = 0; k < DST; k++) begin : g_div
        svpwm_div_stage #(
            .BIT (DST - 1 - k)
        ) u_div (
            .aclk    (aclk),
            .adv     (rdy[FST+k]),
            .div_in  (dchain[k]),
            .div_out (dchain[k+1])
        );
    end

    svpwm_back u_back (
        .aclk          (aclk),
        .adv           (rdy[NSTG-1]),
        .div_in        (dchain[DST]),
        .pwm_period    (period_reg),
        .neutral_count (neutral_reg),
        .duty_a        (m_duty_a),
        .duty_b        (m_duty_b),
        .duty_c        (m_duty_c),
        .sector        (m_sector),
        .overmodulated (m_overmodulated)
    );

    // an empty output stage never blocks the input
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NSTG-1] |-> s_ready)
        else $error("input stalled with empty output stage");

    // a full, stalled pipeline refuses new requests
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("request taken into full stalled pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // sector code seven is never produced
    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sector != 3'd7)
        else $error("sector out of range");

endmodule
